// ----- design/mm4op_pkg.sv -----
// shared types and constants for the 4x4 outer-product matrix multiplier
package mm4op_pkg;

	localparam int unsigned DIM    = 4;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned PROD_W = 2 * DATA_W;
	localparam int unsigned ACC_W  = 50;
	localparam int unsigned IDX_W  = 2;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic [IDX_W-1:0]         idx_t;

	// step codes and row codes
	localparam idx_t STEP_FIRST = 2'd0;
	localparam idx_t STEP_LAST  = 2'd3;
	localparam idx_t ROW_FIRST  = 2'd0;
	localparam idx_t ROW_LAST   = 2'd3;

endpackage

// ----- design/mm4op_in_if.sv -----
// input channel: one column of a and one row of b per item
interface mm4op_in_if;
	logic               valid;
	logic               ready;
	mm4op_pkg::idx_t    step;
	mm4op_pkg::data_t   a0;
	mm4op_pkg::data_t   a1;
	mm4op_pkg::data_t   a2;
	mm4op_pkg::data_t   a3;
	mm4op_pkg::data_t   b0;
	mm4op_pkg::data_t   b1;
	mm4op_pkg::data_t   b2;
	mm4op_pkg::data_t   b3;

	modport source (output valid, step, a0, a1, a2, a3, b0, b1, b2, b3, input ready);
	modport sink (input valid, step, a0, a1, a2, a3, b0, b1, b2, b3, output ready);
endinterface

// ----- design/mm4op_out_if.sv -----
// output channel: one saturated row of c per item
interface mm4op_out_if;
	logic               valid;
	logic               ready;
	mm4op_pkg::idx_t    row;
	mm4op_pkg::data_t   c0;
	mm4op_pkg::data_t   c1;
	mm4op_pkg::data_t   c2;
	mm4op_pkg::data_t   c3;
	logic               clipped;
	logic               last;

	modport source (output valid, row, c0, c1, c2, c3, clipped, last, input ready);
	modport sink (input valid, row, c0, c1, c2, c3, clipped, last, output ready);
endinterface

// ----- design/matrix_multiply_4x4_outer_product.sv -----
// 4x4 fixed-point matrix multiplier built from four rank-one updates
//
// c = a x b in signed fixed point with FRAC_BITS fraction bits (q16.16 by
// default). input item k carries column k of a and row k of b; sixteen
// 32x32 multipliers form the outer product and sixteen 50-bit accumulators
// add it in (step 0 restarts the sums, steps 1 and 2 add, step 3 adds and
// then releases the result). each product is the exact 64-bit product
// shifted arithmetically right by FRAC_BITS. the block takes one input item
// per cycle while it is not stalled; the input register, the product
// register and the accumulator form three stages, and a step-3 item's sums
// are copied, saturated to 32 bits, into a result bank once the bank is
// free, and that bank then offers the rows of c. it releases one row per
// cycle while the sink is ready, row 0 first, with clipped set when
// any element of the row saturated and last set on row 3. the only stall
// comes from the result bank: if a new set of sums is ready while rows of
// the previous set are still waiting to be taken, the whole pipeline holds
// and input ready drops until the last row leaves. with four items per
// matrix and an always-ready sink the block never stalls. missing or
// repeated steps are not detected; each item acts on its own step code.
module matrix_multiply_4x4_outer_product #(
	parameter int unsigned FRAC_BITS = 16
) (
	input logic          clk,
	input logic          arst_n,
	mm4op_in_if.sink     din,
	mm4op_out_if.source  dout
);

	localparam int unsigned N = mm4op_pkg::DIM;

	// stage 1: input register
	logic                   valid_s1;
	mm4op_pkg::idx_t        step_s1;
	mm4op_pkg::data_t       a_s1 [N];
	mm4op_pkg::data_t       b_s1 [N];

	// stage 2: product register
	logic                   valid_s2;
	mm4op_pkg::idx_t        step_s2;
	mm4op_pkg::prod_t       prod_s2 [N][N];

	// accumulators and result bank
	mm4op_pkg::acc_t        acc_q [N][N];
	logic                   pend_q;
	mm4op_pkg::data_t       sat_q [N][N];
	logic [N-1:0]           clip_q;
	logic                   bank_valid_q;
	mm4op_pkg::idx_t        row_q;

	logic                   en;
	logic                   in_fire;
	logic                   out_fire;
	logic                   bank_free;
	logic                   bank_load;
	mm4op_pkg::acc_t        term [N][N];
	mm4op_pkg::data_t       sat_d [N][N];
	logic [N-1:0]           clip_d;

	// bank frees up when it is empty or its last row leaves this cycle
	assign out_fire  = dout.valid && dout.ready;
	assign bank_free = !bank_valid_q || (out_fire && dout.last);
	assign bank_load = pend_q && bank_free;
	// global stall: hold everything while finished sums wait for the bank
	assign en        = !pend_q || bank_free;
	assign din.ready = en;
	assign in_fire   = din.valid && din.ready;

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			step_s1 <= din.step;
			a_s1[0] <= din.a0;
			a_s1[1] <= din.a1;
			a_s1[2] <= din.a2;
			a_s1[3] <= din.a3;
			b_s1[0] <= din.b0;
			b_s1[1] <= din.b1;
			b_s1[2] <= din.b2;
			b_s1[3] <= din.b3;
		end
	end

	// stage 2: sixteen multipliers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_s1) begin
			step_s2 <= step_s1;
			for (int i = 0; i < N; i++) begin
				for (int j = 0; j < N; j++) begin
					prod_s2[i][j] <= mm4op_pkg::PROD_W'(a_s1[i]) *
						mm4op_pkg::PROD_W'(b_s1[j]);
				end
			end
		end
	end

	// scale each product back to the fixed-point grid, keep the accumulator width
	always_comb begin
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++) begin
				term[i][j] = mm4op_pkg::ACC_W'(prod_s2[i][j] >>> FRAC_BITS);
			end
		end
	end

	// stage 3: accumulate, wrapping at 50 bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			for (int i = 0; i < N; i++) begin
				for (int j = 0; j < N; j++) begin
					acc_q[i][j] <= '0;
				end
			end
		end else if (en) begin
			pend_q <= valid_s2 && (step_s2 == mm4op_pkg::STEP_LAST);
			if (valid_s2) begin
				for (int i = 0; i < N; i++) begin
					for (int j = 0; j < N; j++) begin
						if (step_s2 == mm4op_pkg::STEP_FIRST) begin
							acc_q[i][j] <= term[i][j];
						end else begin
							acc_q[i][j] <= acc_q[i][j] + term[i][j];
						end
					end
				end
			end
		end
	end

	// saturate to 32 bits: in range when the bits above the sign bit agree with it
	always_comb begin
		for (int i = 0; i < N; i++) begin
			clip_d[i] = 1'b0;
			for (int j = 0; j < N; j++) begin
				if ((&acc_q[i][j][mm4op_pkg::ACC_W-1:mm4op_pkg::DATA_W-1]) ||
					!(|acc_q[i][j][mm4op_pkg::ACC_W-1:mm4op_pkg::DATA_W-1])) begin
					sat_d[i][j] = acc_q[i][j][mm4op_pkg::DATA_W-1:0];
				end else begin
					clip_d[i] = 1'b1;
					sat_d[i][j] = acc_q[i][j][mm4op_pkg::ACC_W-1] ?
						{1'b1, {(mm4op_pkg::DATA_W-1){1'b0}}} :
						{1'b0, {(mm4op_pkg::DATA_W-1){1'b1}}};
				end
			end
		end
	end

	// result bank: loaded once per matrix, drained one row per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_valid_q <= 1'b0;
			row_q        <= mm4op_pkg::ROW_FIRST;
		end else if (bank_load) begin
			bank_valid_q <= 1'b1;
			row_q        <= mm4op_pkg::ROW_FIRST;
		end else if (out_fire) begin
			if (row_q == mm4op_pkg::ROW_LAST) begin
				bank_valid_q <= 1'b0;
				row_q        <= mm4op_pkg::ROW_FIRST;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bank_load) begin
			sat_q  <= sat_d;
			clip_q <= clip_d;
		end
	end

	assign dout.valid   = bank_valid_q;
	assign dout.row     = row_q;
	assign dout.c0      = sat_q[row_q][0];
	assign dout.c1      = sat_q[row_q][1];
	assign dout.c2      = sat_q[row_q][2];
	assign dout.c3      = sat_q[row_q][3];
	assign dout.clipped = clip_q[row_q];
	assign dout.last    = (row_q == mm4op_pkg::ROW_LAST);

`ifndef SYNTH
	// a freshly loaded bank offers row 0
	a_load_row0: assert property (@(posedge clk) disable iff (!arst_n)
		bank_load |=> (dout.valid && (dout.row == mm4op_pkg::ROW_FIRST)))
		else $error("bank load did not present row 0");

	// last row taken with nothing new to load empties the bank
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_fire && dout.last && !bank_load) |=> !dout.valid)
		else $error("bank still valid after last row");

	// input only stalls when finished sums wait on a busy bank
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> (pend_q && bank_valid_q))
		else $error("input stalled without cause");

	// pending sums only come from a step-3 item leaving the product stage
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_q) |-> $past(valid_s2 && (step_s2 == mm4op_pkg::STEP_LAST)))
		else $error("pending flag set without a final step");
`endif

endmodule

// ----- sim/testbench.sv -----
// self-checking testbench for the 4x4 outer-product fixed-point matrix multiplier
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned FRAC_BITS   = 16;
	// pipeline is three stages deep plus four rows out of the result bank
	localparam int unsigned TAIL_CYCLES = 20;
	localparam int unsigned LIMIT_NS    = 2_000_000;

	localparam mm4op_pkg::data_t WORD_MAX = 32'sh7fffffff;
	localparam mm4op_pkg::data_t WORD_MIN = 32'sh80000000;
	localparam mm4op_pkg::data_t WORD_ONE = 32'sh00010000;
	localparam mm4op_pkg::acc_t  SAT_HI   = mm4op_pkg::acc_t'(WORD_MAX);
	localparam mm4op_pkg::acc_t  SAT_LO   = mm4op_pkg::acc_t'(WORD_MIN);

	// one column of a and one row of b
	typedef struct packed {
		mm4op_pkg::idx_t                        step;
		mm4op_pkg::data_t [mm4op_pkg::DIM-1:0]  a;
		mm4op_pkg::data_t [mm4op_pkg::DIM-1:0]  b;
	} col_row_t;

	// one saturated row of c
	typedef struct packed {
		mm4op_pkg::idx_t                        row;
		mm4op_pkg::data_t [mm4op_pkg::DIM-1:0]  c;
		logic                                   clipped;
		logic                                   last;
	} c_row_t;

	// how the words of a random matrix are chosen
	typedef enum int {FILL_SMALL, FILL_EDGE, FILL_FULL, FILL_MIXED} fill_t;

	logic clk;
	logic arst_n = 1'b0;

	mm4op_in_if  din_if ();
	mm4op_out_if dout_if ();

	matrix_multiply_4x4_outer_product #(
		.FRAC_BITS(FRAC_BITS)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	// driver-side registers, known from time zero
	logic     drv_valid = 1'b0;
	col_row_t drv_item  = '0;
	logic     rcv_ready = 1'b0;

	assign din_if.valid = drv_valid;
	assign din_if.step  = drv_item.step;
	assign din_if.a0    = drv_item.a[0];
	assign din_if.a1    = drv_item.a[1];
	assign din_if.a2    = drv_item.a[2];
	assign din_if.a3    = drv_item.a[3];
	assign din_if.b0    = drv_item.b[0];
	assign din_if.b1    = drv_item.b[1];
	assign din_if.b2    = drv_item.b[2];
	assign din_if.b3    = drv_item.b[3];
	assign dout_if.ready = rcv_ready;

	col_row_t          pending_cols [$];
	c_row_t            expected_rows [$];
	mm4op_pkg::acc_t   model_sums [16];
	int unsigned items_queued  = 0;
	int unsigned err_count     = 0;
	int unsigned send_idle_pct = 28;
	int unsigned recv_idle_pct = 77;

	// clamp a 50-bit sum to the signed 32-bit range
	function automatic mm4op_pkg::data_t saturate(mm4op_pkg::acc_t v, output logic hit);
		hit = 1'b0;
		if (v > SAT_HI) begin
			hit = 1'b1;
			return WORD_MAX;
		end
		if (v < SAT_LO) begin
			hit = 1'b1;
			return WORD_MIN;
		end
		return mm4op_pkg::data_t'(v);
	endfunction

	// rank-one update of the sums; a last step also yields the four rows of c
	function automatic void accumulate_outer(col_row_t it);
		mm4op_pkg::prod_t  p;
		mm4op_pkg::acc_t   sh;
		c_row_t            r;
		logic              hit;
		for (int i = 0; i < mm4op_pkg::DIM; i++) begin
			for (int j = 0; j < mm4op_pkg::DIM; j++) begin
				p = mm4op_pkg::prod_t'($signed(it.a[i])) *
					mm4op_pkg::prod_t'($signed(it.b[j]));
				sh = mm4op_pkg::acc_t'(p >>> FRAC_BITS);
				// step 0 restarts, anything else adds, wrapping at 50 bits
				if (it.step == mm4op_pkg::STEP_FIRST) begin
					model_sums[mm4op_pkg::DIM*i+j] = sh;
				end else begin
					model_sums[mm4op_pkg::DIM*i+j] = model_sums[mm4op_pkg::DIM*i+j] + sh;
				end
			end
		end
		if (it.step == mm4op_pkg::STEP_LAST) begin
			for (int i = 0; i < mm4op_pkg::DIM; i++) begin
				r.row = mm4op_pkg::idx_t'(i);
				r.clipped = 1'b0;
				for (int j = 0; j < mm4op_pkg::DIM; j++) begin
					r.c[j] = saturate(model_sums[mm4op_pkg::DIM*i+j], hit);
					r.clipped = r.clipped | hit;
				end
				r.last = (r.row == mm4op_pkg::ROW_LAST);
				expected_rows.push_back(r);
			end
		end
	endfunction

	function automatic void check_row(c_row_t got);
		c_row_t want;
		if (expected_rows.size() == 0) begin
			$error("row %0d of c arrived with nothing expected", got.row);
			err_count++;
			return;
		end
		want = expected_rows.pop_front();
		if (got.row !== want.row) begin
			$error("row: expected %0d, got %0d", want.row, got.row);
			err_count++;
		end
		for (int j = 0; j < mm4op_pkg::DIM; j++) begin
			if (got.c[j] !== want.c[j]) begin
				$error("c%0d: expected %0d, got %0d", j, $signed(want.c[j]),
					$signed(got.c[j]));
				err_count++;
			end
		end
		if (got.clipped !== want.clipped) begin
			$error("clipped: expected %0d, got %0d", want.clipped, got.clipped);
			err_count++;
		end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			err_count++;
		end
	endfunction

	function automatic mm4op_pkg::data_t pick_word(fill_t fill);
		fill_t f;
		f = fill;
		if (f == FILL_MIXED) begin
			f = fill_t'($urandom_range(2));
		end
		case (f)
			// about +-16.0, keeps most sums inside the 32-bit range
			FILL_SMALL: return mm4op_pkg::data_t'($urandom_range(2097151)) - 32'sd1048576;
			FILL_EDGE: begin
				case ($urandom_range(6))
					0: return WORD_MAX;
					1: return WORD_MIN;
					2: return 32'sd0;
					3: return 32'sd1;
					4: return -32'sd1;
					5: return WORD_ONE;
					default: return -WORD_ONE;
				endcase
			end
			default: return mm4op_pkg::data_t'($urandom);
		endcase
	endfunction

	function automatic void push_raw(mm4op_pkg::idx_t s,
		mm4op_pkg::data_t [mm4op_pkg::DIM-1:0] a,
		mm4op_pkg::data_t [mm4op_pkg::DIM-1:0] b);
		col_row_t it;
		it.step = s;
		it.a = a;
		it.b = b;
		pending_cols.push_back(it);
		items_queued++;
	endfunction

	function automatic void push_item(mm4op_pkg::idx_t s, fill_t fill);
		mm4op_pkg::data_t [mm4op_pkg::DIM-1:0] a;
		mm4op_pkg::data_t [mm4op_pkg::DIM-1:0] b;
		for (int i = 0; i < mm4op_pkg::DIM; i++) begin
			a[i] = pick_word(fill);
			b[i] = pick_word(fill);
		end
		push_raw(s, a, b);
	endfunction

	function automatic fill_t pick_fill();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50) return FILL_SMALL;
		if (r < 70) return FILL_EDGE;
		if (r < 85) return FILL_FULL;
		return FILL_MIXED;
	endfunction

	// a well-formed product, or now and then a lone item or a broken sequence
	function automatic void push_sequence();
		int unsigned odd;
		fill_t       fill;
		fill = pick_fill();
		if ($urandom_range(99) < 85) begin
			for (int k = 0; k < mm4op_pkg::DIM; k++) begin
				push_item(mm4op_pkg::idx_t'(k), fill);
			end
			return;
		end
		odd = $urandom_range(3);
		case ($urandom_range(2))
			0: push_item(mm4op_pkg::idx_t'($urandom_range(3)), fill);
			1: begin
				// one step left out
				for (int k = 0; k < mm4op_pkg::DIM; k++) begin
					if (k != odd) begin
						push_item(mm4op_pkg::idx_t'(k), fill);
					end
				end
			end
			default: begin
				// one step sent twice
				for (int k = 0; k < mm4op_pkg::DIM; k++) begin
					push_item(mm4op_pkg::idx_t'(k), fill);
					if (k == odd) begin
						push_item(mm4op_pkg::idx_t'(k), fill);
					end
				end
			end
		endcase
	endfunction

	// hold the sender until everything sent has come back as rows of c
	task automatic drain_all();
		@(negedge clk);
		while (pending_cols.size() != 0 || drv_valid || expected_rows.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, int unsigned n);
		int unsigned target;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = items_queued + n;
		while (items_queued < target) begin
			push_sequence();
		end
		drain_all();
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// driver: present the next pending item, hold it until it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else begin
			if (drv_valid && din_if.ready) begin
				accumulate_outer(drv_item);
			end
			if (!drv_valid || din_if.ready) begin
				if (pending_cols.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_item  <= pending_cols.pop_front();
					drv_valid <= 1'b1;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: take rows of c with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_ready <= 1'b0;
		end else begin
			if (dout_if.valid && rcv_ready) begin
				check_row(c_row_t'({dout_if.row, dout_if.c3, dout_if.c2, dout_if.c1,
					dout_if.c0, dout_if.clipped, dout_if.last}));
			end
			rcv_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		mm4op_pkg::data_t [mm4op_pkg::DIM-1:0] a;
		mm4op_pkg::data_t [mm4op_pkg::DIM-1:0] b;

		for (int i = 0; i < 16; i++) begin
			model_sums[i] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// extremes: rows of max and min clip both ways, min*min included,
		// and an all-zero row that must not clip
		a = {32'sd0, WORD_MAX, WORD_MIN, WORD_MAX};
		b = {WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX};
		for (int k = 0; k < mm4op_pkg::DIM; k++) begin
			push_raw(mm4op_pkg::idx_t'(k), a, b);
		end

		// identity times small rows: c must equal b exactly
		for (int k = 0; k < mm4op_pkg::DIM; k++) begin
			for (int i = 0; i < mm4op_pkg::DIM; i++) begin
				a[i] = (i == k) ? WORD_ONE : 32'sd0;
				b[i] = pick_word(FILL_SMALL);
			end
			push_raw(mm4op_pkg::idx_t'(k), a, b);
		end

		// floor rounding: -1 lsb times 1 lsb gives -1, 1 times 1 gives 0
		push_raw(mm4op_pkg::STEP_FIRST, {mm4op_pkg::DIM{-32'sd1}}, {mm4op_pkg::DIM{32'sd1}});
		for (int k = 1; k < mm4op_pkg::DIM; k++) begin
			push_raw(mm4op_pkg::idx_t'(k), {mm4op_pkg::DIM{32'sd1}},
				{mm4op_pkg::DIM{32'sd1}});
		end

		// lone last step adds zero onto the kept sums and emits them again
		push_raw(mm4op_pkg::STEP_LAST, '0, '0);

		// steps out of order: repeated step 1, no step 0 or 2, then step 3
		push_item(2'd1, FILL_SMALL);
		push_item(2'd1, FILL_SMALL);
		push_item(mm4op_pkg::STEP_LAST, FILL_SMALL);

		// lone step 2, then step 0 twice restarts, then step 3 emits
		push_item(2'd2, FILL_EDGE);
		push_item(mm4op_pkg::STEP_FIRST, FILL_FULL);
		push_item(mm4op_pkg::STEP_FIRST, FILL_SMALL);
		push_item(mm4op_pkg::STEP_LAST, FILL_SMALL);

		run_phase(28, 77, 140);
		run_phase(77, 28, 135);
		run_phase(0, 0, 135);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_rows.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// watchdog for a stuck handshake
	initial begin
		#(LIMIT_NS);
		$display("Simulation FAILED");
		$finish;
	end

endmodule
